// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that prop holds on every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Check that cond never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== src/nlej_pkg.sv =====
// Package: constants and types of the nested-loop equality join engine.
`timescale 1ns / 1ps
`default_nettype none
package nlej_pkg;
  localparam int DEPTH   = 64;
  localparam int KEY_W   = 32;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int PROBE_W = 24;
  localparam int TOTAL_W = 32;
  localparam int MODE_W  = 2;

  localparam logic [CNT_W-1:0]   DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_PROBE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic scanning;
    logic flushing;
  } ctrl_t;
endpackage
`default_nettype wire

// ===== src/nlej_in_if.sv =====
// Request channel interface: mode and key with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface nlej_in_if import nlej_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  key;
  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface
`default_nettype wire

// ===== src/nlej_out_if.sv =====
// Result channel interface: one join match with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface nlej_out_if import nlej_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PROBE_W-1:0] probe_index;
  logic [IDX_W-1:0]   build_index;
  logic [KEY_W-1:0]   match_key;
  logic [TOTAL_W-1:0] match_total;
  logic               last_of_run;
  logic               overflowed;
  modport source (output valid, output probe_index, output build_index, output match_key,
                  output match_total, output last_of_run, output overflowed, input ready);
  modport sink (input valid, input probe_index, input build_index, input match_key,
                input match_total, input last_of_run, input overflowed, output ready);
endinterface
`default_nettype wire

// ===== src/nlej_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module nlej_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/nested_loop_equi_join.sv =====
// Top level: nested-loop equality join engine over a key RAM.
// Load requests append a key to a 64-entry key RAM (further loads are dropped and raise
// the overflowed flag); a clear request empties the store and zeroes all counters.
// Loads, clears and unused modes leave the engine idle. A probe request reads the stored
// keys from the key RAM one per cycle, while no match waits on a stalled result channel,
// in ascending order and compares each with the probe key. One match is held back until
// the next one is found, so that the final match of a probe can carry last_of_run. A
// probe with no match returns nothing. Requests are taken while an earlier result still
// waits.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nested_loop_equi_join import nlej_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  nlej_in_if.sink     req,
  nlej_out_if.source  result
);
  state_t state, state_next;
  ctrl_t  ctrl;

  logic [CNT_W-1:0]   stored_count;
  logic [PROBE_W-1:0] probe_counter;
  logic [TOTAL_W-1:0] match_counter;
  logic               overflow_flag;

  logic [KEY_W-1:0]   probe_key;
  logic [CNT_W-1:0]   scan_addr;
  logic               cmp_valid;
  logic [IDX_W-1:0]   cmp_idx;

  logic               pend_valid;
  logic [IDX_W-1:0]   pend_build;
  logic [TOTAL_W-1:0] pend_total;

  logic               res_valid;
  logic [PROBE_W-1:0] res_probe;
  logic [IDX_W-1:0]   res_build;
  logic [KEY_W-1:0]   res_key;
  logic [TOTAL_W-1:0] res_total;
  logic               res_last;
  logic               res_ovf;

  logic               req_fire;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  logic [KEY_W-1:0]   ram_rdata;
  logic               out_free;
  logic               match_now;
  logic               stall;
  logic               issue;
  logic               scan_done;
  logic               push_mid;
  logic               push_last;
  logic               finish;
  logic [TOTAL_W-1:0] total_next;

  assign req_fire  = req.valid && ctrl.in_ready;
  assign out_free  = !res_valid || result.ready;
  assign match_now = ctrl.scanning && cmp_valid && (ram_rdata == probe_key);
  assign stall     = match_now && pend_valid && !out_free;
  assign issue     = ctrl.scanning && !stall && (scan_addr < stored_count);
  assign scan_done = ctrl.scanning && !cmp_valid && (scan_addr >= stored_count);
  assign push_mid  = match_now && pend_valid && !stall;
  assign finish    = ctrl.flushing && (!pend_valid || out_free);
  assign push_last = finish && pend_valid;
  assign total_next = (match_counter == TOTAL_MAX) ? TOTAL_MAX : match_counter + 1'b1;

  assign ram_we    = req_fire && (mode_t'(req.mode) == MODE_LOAD) && (stored_count < DEPTH_CNT);
  // Re-read the entry under comparison while the result channel holds us up.
  assign ram_raddr = stall ? cmp_idx : scan_addr[IDX_W-1:0];

  nlej_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stored_count[IDX_W-1:0]),
    .wdata (req.key),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && (mode_t'(req.mode) == MODE_PROBE)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_IDLE:  ctrl.in_ready = 1'b1;
      ST_SCAN:  ctrl.scanning = 1'b1;
      ST_FLUSH: ctrl.flushing = 1'b1;
      default:  ctrl = '0;
    endcase
  end

  assign req.ready = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      stored_count  <= '0;
      probe_counter <= '0;
      match_counter <= '0;
      overflow_flag <= 1'b0;
      cmp_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      res_valid     <= 1'b0;
      scan_addr     <= '0;
    end else begin
      state <= state_next;

      if (req_fire) begin
        case (mode_t'(req.mode))
          MODE_CLEAR: begin
            stored_count  <= '0;
            probe_counter <= '0;
            match_counter <= '0;
            overflow_flag <= 1'b0;
          end
          MODE_LOAD: begin
            if (stored_count < DEPTH_CNT) begin
              stored_count <= stored_count + 1'b1;
            end else begin
              overflow_flag <= 1'b1;
            end
          end
          MODE_PROBE: begin
            scan_addr <= '0;
            cmp_valid <= 1'b0;
          end
          default: ;
        endcase
      end

      // Advance the scan unless a match waits for the result channel.
      if (ctrl.scanning && !stall) begin
        cmp_valid <= issue;
        if (issue) begin
          scan_addr <= scan_addr + 1'b1;
        end
      end

      if (match_now && !stall) begin
        pend_valid    <= 1'b1;
        match_counter <= total_next;
      end

      if (finish) begin
        pend_valid    <= 1'b0;
        probe_counter <= probe_counter + 1'b1;
      end

      if (push_mid || push_last) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      probe_key <= req.key;
    end
    if (issue) begin
      cmp_idx <= scan_addr[IDX_W-1:0];
    end
    if (match_now && !stall) begin
      pend_build <= cmp_idx;
      pend_total <= total_next;
    end
    if (push_mid || push_last) begin
      res_probe <= probe_counter;
      res_build <= pend_build;
      res_key   <= probe_key;
      res_total <= pend_total;
      res_last  <= push_last;
      res_ovf   <= overflow_flag;
    end
  end

  assign result.valid       = res_valid;
  assign result.probe_index = res_probe;
  assign result.build_index = res_build;
  assign result.match_key   = res_key;
  assign result.match_total = res_total;
  assign result.last_of_run = res_last;
  assign result.overflowed  = res_ovf;

  `ASSERT_HOLDS(a_idle_no_pend, clk, rst, (state == ST_IDLE) |-> !pend_valid)
  `ASSERT_HOLDS(a_count_bound, clk, rst, stored_count <= DEPTH_CNT)
  `ASSERT_NEVER(a_push_blocked, clk, rst, (push_mid || push_last) && res_valid && !result.ready)
  `ASSERT_HOLDS(a_cmp_in_store, clk, rst,
                (ctrl.scanning && cmp_valid) |-> ({1'b0, cmp_idx} < stored_count))
endmodule
`default_nettype wire
